FILE: rtl/sqzh_pkg.sv
// sqzh_pkg: widths, constants and stage structs of the squeeze histogram block
// used by every file of the block but sqzh_ram; depends on nothing
package sqzh_pkg;

    localparam int NUM_BINS    = 43;
    localparam int COUNT_WIDTH = 24;
    localparam int BIN_AW      = $clog2(NUM_BINS);

    localparam int CFG_W   = 24;
    localparam int WORD_W  = 32;
    localparam int K_W     = 31;
    localparam int PROD_W  = WORD_W + K_W;
    localparam int STEP_W  = 6;
    localparam int SEL_W   = 6;
    localparam int DISC_W  = 32;

    localparam logic [K_W-1:0]         K_START    = {K_W{1'b1}};
    localparam logic [STEP_W-1:0]      STEP_LIMIT = 6'd48;
    localparam logic [STEP_W-1:0]      BIN_OFFSET = 6'd6;
    localparam logic [CFG_W-1:0]       MAXN_RESET = 24'd100000;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [DISC_W-1:0]      DISC_MAX   = {DISC_W{1'b1}};

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int OUTQ_DEPTH = 3;
    localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
    localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

    // squeeze stage result handed to the histogram stage
    typedef struct packed {
        logic                   is_read;
        logic                   used;
        logic                   done;
        logic [SEL_W-1:0]       bin;
        logic [SEL_W-1:0]       slot;
        logic                   in_range;
        logic [COUNT_WIDTH-1:0] tally;
        logic [DISC_W-1:0]      discard;
    } t_s0;

    typedef struct packed {
        logic                   word_used;
        logic                   number_done;
        logic [SEL_W-1:0]       done_bin;
        logic [COUNT_WIDTH-1:0] bin_value;
        logic [COUNT_WIDTH-1:0] numbers_tallied;
        logic [DISC_W-1:0]      words_discarded;
    } t_res;

endpackage

FILE: rtl/sqzh_in_if.sv
// sqzh_in_if: valid/ready channel carrying one input word of the squeeze histogram
// depends on sqzh_pkg
interface sqzh_in_if;
    import sqzh_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [WORD_W-1:0]  rand_word;
    logic [SEL_W-1:0]   read_bin;

    modport source (output valid, cmd, rand_word, read_bin, input ready);
    modport sink   (input valid, cmd, rand_word, read_bin, output ready);
endinterface

FILE: rtl/sqzh_out_if.sv
// sqzh_out_if: valid/ready channel carrying one result word of the squeeze histogram
// depends on sqzh_pkg
interface sqzh_out_if;
    import sqzh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   word_used;
    logic                   number_done;
    logic [SEL_W-1:0]       done_bin;
    logic [COUNT_WIDTH-1:0] bin_value;
    logic [COUNT_WIDTH-1:0] numbers_tallied;
    logic [DISC_W-1:0]      words_discarded;

    modport source (output valid, word_used, number_done, done_bin, bin_value,
                    numbers_tallied, words_discarded, input ready);
    modport sink   (input valid, word_used, number_done, done_bin, bin_value,
                    numbers_tallied, words_discarded, output ready);
endinterface

FILE: rtl/sqzh_ram.sv
// sqzh_ram: generic single-write, single-read ram with registered read data
// no dependencies
module sqzh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/sqzh_squeeze.sv
// sqzh_squeeze: squeeze recurrence, step count, tally, discard count and limit register
// depends on sqzh_pkg
module sqzh_squeeze (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sqzh_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_acc,
    input  logic                       i_cmd,
    input  logic [sqzh_pkg::WORD_W-1:0] i_word,
    input  logic [sqzh_pkg::SEL_W-1:0] i_read_bin,
    output sqzh_pkg::t_s0              o_s0
);
    import sqzh_pkg::*;

    logic [K_W-1:0]         r_k, n_k;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [COUNT_WIDTH-1:0] r_tally, n_tally;
    logic [DISC_W-1:0]      r_disc, n_disc;
    logic [CFG_W-1:0]       r_max;

    logic [PROD_W-1:0]  prod;
    logic [K_W-1:0]     k_sq;
    logic [STEP_W-1:0]  step_inc;
    logic [SEL_W-1:0]   bin;
    logic               limit;
    logic               is_read;
    logic               is_done;
    logic               used;
    logic [SEL_W-1:0]   slot;

    always_comb begin
        prod     = PROD_W'(i_word) * PROD_W'(r_k);
        // ceiling of the product over 2^32
        k_sq     = prod[PROD_W-1:WORD_W] + K_W'(prod[WORD_W-1:0] != '0);
        step_inc = r_step + STEP_W'(1);
        is_done  = (k_sq == K_W'(1)) || (step_inc >= STEP_LIMIT);
        bin      = (step_inc < BIN_OFFSET) ? '0 : SEL_W'(step_inc - BIN_OFFSET);
        limit    = 32'(r_tally) >= 32'(r_max);
        is_read  = (i_cmd == CMD_READ);
        used     = !is_read && !limit;

        n_k     = r_k;
        n_step  = r_step;
        n_tally = r_tally;
        n_disc  = r_disc;
        if (i_acc && used) begin
            n_k    = is_done ? K_START : k_sq;
            n_step = is_done ? '0 : step_inc;
            if (is_done && r_tally != COUNT_MAX) begin
                n_tally = r_tally + COUNT_WIDTH'(1);
            end
        end else if (i_acc && !is_read) begin
            if (r_disc != DISC_MAX) begin
                n_disc = r_disc + DISC_W'(1);
            end
        end

        slot = is_read ? i_read_bin : bin;

        o_s0.is_read  = is_read;
        o_s0.used     = used;
        o_s0.done     = used && is_done;
        o_s0.bin      = (used && is_done) ? bin : '0;
        o_s0.slot     = slot;
        o_s0.in_range = ({1'b0, slot} < (SEL_W+1)'(NUM_BINS));
        o_s0.tally    = n_tally;
        o_s0.discard  = n_disc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= K_START;
            r_step  <= '0;
            r_tally <= '0;
            r_disc  <= '0;
            r_max   <= MAXN_RESET;
        end else begin
            r_k     <= n_k;
            r_step  <= n_step;
            r_tally <= n_tally;
            r_disc  <= n_disc;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end
endmodule

FILE: rtl/sqzh_hist.sv
// sqzh_hist: bin count memory with read-modify-write, valid bits and write forwarding
// depends on sqzh_pkg and sqzh_ram
module sqzh_hist (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  sqzh_pkg::t_s0  i_s0,
    output logic           o_s1_vld,
    output sqzh_pkg::t_res o_res
);
    import sqzh_pkg::*;

    logic [NUM_BINS-1:0]    r_vld;
    logic                   r_s1_vld;
    t_s0                    r_s1;
    logic                   r_rd_vld;
    logic                   r_fw_vld;
    logic [BIN_AW-1:0]      r_fw_addr;
    logic [COUNT_WIDTH-1:0] r_fw_data;

    logic [BIN_AW-1:0]      rd_addr;
    logic [BIN_AW-1:0]      s1_addr;
    logic [COUNT_WIDTH-1:0] ram_q;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] wdata;
    logic                   wr_en;

    assign rd_addr = i_s0.slot[BIN_AW-1:0];
    assign s1_addr = r_s1.slot[BIN_AW-1:0];

    sqzh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (s1_addr),
        .i_wdata (wdata),
        .i_re    (i_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        // the ram returns old data when last cycle's write hit the same bin
        if (r_fw_vld && r_fw_addr == s1_addr) begin
            cur = r_fw_data;
        end else if (r_rd_vld) begin
            cur = ram_q;
        end else begin
            cur = '0;
        end
        wr_en = r_s1_vld && r_s1.done && r_s1.in_range;
        wdata = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

        o_res.word_used       = r_s1.used;
        o_res.number_done     = r_s1.done;
        o_res.done_bin        = r_s1.bin;
        o_res.bin_value       = (r_s1.is_read && r_s1.in_range) ? cur : '0;
        o_res.numbers_tallied = r_s1.tally;
        o_res.words_discarded = r_s1.discard;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_s1_vld <= i_acc;
            r_fw_vld <= wr_en;
            if (wr_en) begin
                r_vld[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1     <= i_s0;
            r_rd_vld <= i_s0.in_range && r_vld[rd_addr];
        end
        r_fw_addr <= s1_addr;
        r_fw_data <= wdata;
    end

    assign o_s1_vld = r_s1_vld;
endmodule

FILE: rtl/sqzh_outq.sv
// sqzh_outq: small result queue between the histogram stage and the output channel
// depends on sqzh_pkg
module sqzh_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  sqzh_pkg::t_res             i_res,
    input  logic                       i_pop,
    output logic                       o_vld,
    output sqzh_pkg::t_res             o_res,
    output logic [sqzh_pkg::OQ_CW-1:0] o_count
);
    import sqzh_pkg::*;

    t_res             r_slot [OUTQ_DEPTH];
    logic [OQ_AW-1:0] r_wr;
    logic [OQ_AW-1:0] r_rd;
    logic [OQ_CW-1:0] r_count;

    function automatic logic [OQ_AW-1:0] ptr_next(input logic [OQ_AW-1:0] p);
        ptr_next = (p == OQ_AW'(OUTQ_DEPTH - 1)) ? '0 : p + OQ_AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + OQ_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - OQ_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_res;
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_res   = r_slot[r_rd];
    assign o_count = r_count;
endmodule

FILE: rtl/squeeze_randomness_histogram.sv
// squeeze_randomness_histogram: top level of the squeeze test histogram
// depends on sqzh_pkg, sqzh_in_if, sqzh_out_if, sqzh_squeeze, sqzh_hist, sqzh_outq
//
//  channel   dir  handshake         payload
//  i_in      in   valid / ready     cmd, rand_word, read_bin
//  o_out     out  valid / ready     word_used, number_done, done_bin, bin_value,
//                                   numbers_tallied, words_discarded
//  i_cfg     in   i_cfg_we          i_cfg_wdata (max_numbers)
//
// one word per cycle while ready is high; a result is registered in stage one and
// again in the result queue before it is presented on o_out
// the squeeze multiply is combinational and feeds k straight back; the bin memory
// does one read and one write per cycle, with last-write forwarding on the same bin
// reset clears the bin valid bits at once, so no clearing pass is needed
// a three-entry result queue absorbs output stalls; ready drops once the queue
// plus the staged word hold three results
module squeeze_randomness_histogram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sqzh_in_if.sink                    i_in,
    sqzh_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [sqzh_pkg::CFG_W-1:0] i_cfg_wdata
);
    import sqzh_pkg::*;

    logic             acc;
    logic             pop;
    t_s0              s0;
    t_res             s1_res;
    t_res             q_res;
    logic             s1_vld;
    logic             q_vld;
    logic [OQ_CW-1:0] q_count;
    logic [OQ_CW:0]   inflight;

    assign acc      = i_in.valid && i_in.ready;
    assign pop      = o_out.valid && o_out.ready;
    // stage one always drains into the queue, so count it against free slots
    assign inflight = (OQ_CW+1)'(q_count) + (OQ_CW+1)'(s1_vld);
    assign i_in.ready = (inflight < (OQ_CW+1)'(OUTQ_DEPTH));

    sqzh_squeeze u_squeeze (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_cmd       (i_in.cmd),
        .i_word      (i_in.rand_word),
        .i_read_bin  (i_in.read_bin),
        .o_s0        (s0)
    );

    sqzh_hist u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_s0     (s0),
        .o_s1_vld (s1_vld),
        .o_res    (s1_res)
    );

    sqzh_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_vld),
        .i_res   (s1_res),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_res   (q_res),
        .o_count (q_count)
    );

    assign o_out.valid           = q_vld;
    assign o_out.word_used       = q_res.word_used;
    assign o_out.number_done     = q_res.number_done;
    assign o_out.done_bin        = q_res.done_bin;
    assign o_out.bin_value       = q_res.bin_value;
    assign o_out.numbers_tallied = q_res.numbers_tallied;
    assign o_out.words_discarded = q_res.words_discarded;

`ifndef SYNTH
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_vld |-> (q_count < OQ_CW'(OUTQ_DEPTH)) || pop)
        else $error("result queue overrun");

    a_word_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> s1_vld)
        else $error("accepted word did not reach the histogram stage");

    a_done_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.number_done |-> o_out.word_used)
        else $error("number completed by an unused word");
`endif
endmodule

FILE: tb/sv/squeeze_randomness_histogram_tb.sv
`timescale 1ns / 1ps
// squeeze_randomness_histogram_tb: self-checking bench for the squeeze test histogram
// directed table, then random phases with several max_numbers settings; results are
// checked against a cycle-free predictor; depends on sqzh_pkg, sqzh_in_if, sqzh_out_if
module squeeze_randomness_histogram_tb;
    import sqzh_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int SETTLE_CYCLES   = 10;
    localparam int RAND_PHASES     = 9;
    localparam int PHASE_LIVE      = 90;
    localparam int PHASE_CAP       = 110;
    localparam int N_ROWS          = 22;

    typedef enum logic {RK_ITEM, RK_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              cmd;
        logic [WORD_W-1:0] word;    // register value on a config row
        logic [SEL_W-1:0]  rbin;
        int                reps;
        bit                typed;
        t_res              want;
    } t_stim_row;

    localparam t_res RES_NONE = '0;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    sqzh_in_if  in_ch ();
    sqzh_out_if out_ch ();

    squeeze_randomness_histogram dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [K_W-1:0]         pred_k       = K_START;
    logic [STEP_W-1:0]      pred_step    = '0;
    logic [COUNT_WIDTH-1:0] pred_bins [64];
    logic [COUNT_WIDTH-1:0] pred_tally   = '0;
    logic [DISC_W-1:0]      pred_discard = '0;
    logic [CFG_W-1:0]       pred_max     = MAXN_RESET;

    t_res pending_results [$];
    int   error_count  = 0;
    int   quiet_cycles = 0;
    bit   hold_off_req = 0;
    bit   gaps_on      = 1;
    int   burst_left   = 0;

    t_stim_row dir_rows [N_ROWS] = '{
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd0,  1, 1'b1,
          '{1'b0, 1'b0, 6'd0, 24'd0, 24'd0, 32'd0}},
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd42, 1, 1'b1,
          '{1'b0, 1'b0, 6'd0, 24'd0, 24'd0, 32'd0}},
        // out of range bin reads as zero
        '{RK_ITEM, CMD_READ, 32'hFFFF_FFFF, 6'd63, 1, 1'b1,
          '{1'b0, 1'b0, 6'd0, 24'd0, 24'd0, 32'd0}},
        // word of one squeezes k straight to 1, lands in bin 0
        '{RK_ITEM, CMD_FEED, 32'h0000_0001, 6'd0,  1, 1'b1,
          '{1'b1, 1'b1, 6'd0, 24'd0, 24'd1, 32'd0}},
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd0,  1, 1'b1,
          '{1'b0, 1'b0, 6'd0, 24'd1, 24'd1, 32'd0}},
        // zero word parks k at 0 until the step limit
        '{RK_ITEM, CMD_FEED, 32'h0000_0000, 6'd63, 1, 1'b1,
          '{1'b1, 1'b0, 6'd0, 24'd0, 24'd1, 32'd0}},
        '{RK_ITEM, CMD_FEED, 32'h0000_0000, 6'd0, 47, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd42, 1, 1'b1,
          '{1'b0, 1'b0, 6'd0, 24'd1, 24'd2, 32'd0}},
        // all-ones word keeps k, runs out to bin 42 too
        '{RK_ITEM, CMD_FEED, 32'hFFFF_FFFF, 6'd0, 48, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_FEED, 32'h8000_0000, 6'd0, 40, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_FEED, 32'h0000_0002, 6'd0,  1, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_FEED, 32'hDEAD_BEEF, 6'd0, 30, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd25, 1, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd43, 1, 1'b0, RES_NONE},
        // limit of zero: every fed word discarded
        '{RK_CFG,  CMD_FEED, 32'h0000_0000, 6'd0,  1, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_FEED, 32'h1234_5678, 6'd0,  3, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_READ, 32'h0000_0000, 6'd42, 1, 1'b0, RES_NONE},
        // limit below the current tally
        '{RK_CFG,  CMD_FEED, 32'h0000_0001, 6'd0,  1, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_FEED, 32'h0000_0000, 6'd0,  2, 1'b0, RES_NONE},
        '{RK_CFG,  CMD_FEED, 32'h00FF_FFFF, 6'd0,  1, 1'b0, RES_NONE},
        '{RK_ITEM, CMD_FEED, 32'h0000_0001, 6'd0,  1, 1'b0, RES_NONE},
        '{RK_CFG,  CMD_FEED, 32'h0001_86A0, 6'd0,  1, 1'b0, RES_NONE}
    };

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // next result of the block for one accepted word; advances the predictor
    function automatic t_res squeeze_predict(input logic c, input logic [WORD_W-1:0] w,
                                             input logic [SEL_W-1:0] rb);
        t_res             r;
        logic [63:0]      prod;
        logic [STEP_W-1:0] b;
        r = '0;
        if (c == CMD_READ) begin
            if (rb < NUM_BINS) r.bin_value = pred_bins[rb];
        end else if (pred_tally >= pred_max) begin
            if (pred_discard != DISC_MAX) pred_discard++;
        end else begin
            r.word_used = 1'b1;
            prod = 64'(w) * 64'(pred_k);
            pred_k = K_W'((prod + 64'hFFFF_FFFF) >> 32);
            pred_step = pred_step + 1'b1;
            if (pred_k == 1 || pred_step >= STEP_LIMIT) begin
                b = (pred_step < BIN_OFFSET) ? '0 : pred_step - BIN_OFFSET;
                r.number_done = 1'b1;
                r.done_bin = b;
                if (b < NUM_BINS && pred_bins[b] != COUNT_MAX) pred_bins[b]++;
                if (pred_tally != COUNT_MAX) pred_tally++;
                pred_k = K_START;
                pred_step = '0;
            end
        end
        r.numbers_tallied = pred_tally;
        r.words_discarded = pred_discard;
        return r;
    endfunction

    task automatic offer_word(input logic c, input logic [WORD_W-1:0] w,
                              input logic [SEL_W-1:0] rb, input bit typed,
                              input t_res typed_res, output t_res got);
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c;
        in_ch.rand_word <= w;
        in_ch.read_bin  <= rb;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        got = squeeze_predict(c, w, rb);
        pending_results.push_back(typed ? typed_res : got);
    endtask

    task automatic pause_input(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic sender_gap();
        int idle_n;
        idle_n = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                idle_n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(0, 3);
        end else begin
            burst_left--;
        end
        pause_input(idle_n);
    endtask

    task automatic drain_results();
        pause_input(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_max_numbers(input logic [CFG_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        pred_max = v;
    endtask

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got tally %0d",
                         $time, out_ch.numbers_tallied);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("word_used",       want.word_used,       out_ch.word_used);
                check_field("number_done",     want.number_done,     out_ch.number_done);
                check_field("done_bin",        want.done_bin,        out_ch.done_bin);
                check_field("bin_value",       want.bin_value,       out_ch.bin_value);
                check_field("numbers_tallied", want.numbers_tallied, out_ch.numbers_tallied);
                check_field("words_discarded", want.words_discarded, out_ch.words_discarded);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: 16-bit ready patterns, plus one long hold-off on request
    initial begin : receiver
        logic [15:0] ready_pat;
        int          bitpos;
        ready_pat = '1;
        bitpos = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (bitpos == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pat = '1;
                        1: ready_pat = 16'($urandom | $urandom);
                        2: ready_pat = 16'($urandom);
                        default: ready_pat = 16'($urandom & $urandom);
                    endcase
                end
                out_ch.ready <= ready_pat[bitpos];
                bitpos = (bitpos + 1) % 16;
            end
        end
    end

    initial begin : stimulus
        t_res              got;
        logic              c;
        logic [WORD_W-1:0] w;
        logic [SEL_W-1:0]  rb;
        int                pick;
        int                live;
        int                phase_items;

        for (int i = 0; i < 64; i++) pred_bins[i] = '0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_FEED;
        in_ch.rand_word = '0;
        in_ch.read_bin  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == RK_CFG) begin
                write_max_numbers(CFG_W'(dir_rows[r].word));
            end else begin
                for (int n = 0; n < dir_rows[r].reps; n++) begin
                    offer_word(dir_rows[r].cmd, dir_rows[r].word, dir_rows[r].rbin,
                               dir_rows[r].typed, dir_rows[r].want, got);
                    sender_gap();
                end
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 3)
                0: write_max_numbers(COUNT_MAX);
                // limit lands a few numbers ahead, so it trips mid-phase
                1: write_max_numbers(pred_tally + CFG_W'($urandom_range(2, 12)));
                default: write_max_numbers((ph == 5) ? CFG_W'(1) : MAXN_RESET);
            endcase
            gaps_on = (ph != 2);
            live = 0;
            phase_items = 0;
            while (live < PHASE_LIVE && phase_items < PHASE_CAP) begin
                pick = $urandom_range(0, 99);
                c  = CMD_FEED;
                w  = $urandom;
                rb = '0;
                if (pick < 15) begin
                    c  = CMD_READ;
                    rb = (pick < 12) ? SEL_W'($urandom_range(0, NUM_BINS - 1))
                                     : SEL_W'($urandom_range(NUM_BINS, 63));
                end else if (pick < 20) begin
                    w = '0;
                end else if (pick < 25) begin
                    w = '1;
                end else if (pick < 45) begin
                    w = w >> $urandom_range(0, 31);
                end
                if (ph == 1 && phase_items == 30) hold_off_req = 1;
                if (ph == 4 && phase_items == 60) drain_results();
                offer_word(c, w, rb, 1'b0, RES_NONE, got);
                phase_items++;
                if (c == CMD_READ || got.word_used) live++;
                sender_gap();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
